@@ hdl/sors_pkg.sv @@
// Shared types, codes and constants of the seek-order record scheduler.
package sors_pkg;

  localparam int unsigned DefMaxSlots = 32;
  localparam int unsigned AddrW       = 31;

  // Request codes; code 3 has no meaning and is ignored.
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_DISK  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  // Result kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_RECORDS_PER_BLOCK = 2'd0;
  localparam logic [1:0] REG_BLOCK_LENGTH      = 2'd1;
  localparam logic [1:0] REG_GAP_LENGTH        = 2'd2;
  localparam logic [1:0] REG_TAPE_LIMIT        = 2'd3;

  localparam logic [5:0]  RST_RECORDS_PER_BLOCK = 6'd10;
  localparam logic [15:0] RST_BLOCK_LENGTH      = 16'd100;
  localparam logic [7:0]  RST_GAP_LENGTH        = 8'd7;
  localparam logic [31:0] RST_TAPE_LIMIT        = 32'hFFFF_FFFF;

  localparam logic [AddrW-1:0] PAD_ADDR = AddrW'(1);

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] disk_addr;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [4:0]       slot;
    logic [AddrW-1:0] read_addr;
    logic             tape_full;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_item_t;

  // Command to the cell row.
  typedef struct packed {
    logic ins;  // insert the broadcast entry in address order
    logic pop;  // shift every entry one cell towards the head
  } chain_ctl_t;

endpackage

@@ hdl/sors_chan_if.sv @@
// Valid/ready channel interface carrying one payload item per transaction.
interface sors_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sors_cell.sv @@
// One cell of the sorted slot row: holds one addressed slot entry.
module sors_cell #(
  parameter int unsigned IDX_W = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sors_pkg::chain_ctl_t      ctl,
  input  logic [sors_pkg::AddrW-1:0] ins_addr,
  input  logic [IDX_W-1:0]          ins_slot,
  input  logic                      prev_lt,
  input  logic [sors_pkg::AddrW-1:0] prev_addr,
  input  logic [IDX_W-1:0]          prev_slot,
  input  logic                      prev_vld,
  input  logic [sors_pkg::AddrW-1:0] next_addr,
  input  logic [IDX_W-1:0]          next_slot,
  input  logic                      next_vld,
  output logic                      lt,
  output logic [sors_pkg::AddrW-1:0] addr_r,
  output logic [IDX_W-1:0]          slot_r,
  output logic                      vld_r
);
  import sors_pkg::*;

  // An empty cell counts as holding an infinite key. Equal keys stay in
  // front of the new entry, so ties keep arrival order.
  assign lt = !vld_r || (ins_addr < addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.pop) begin
      vld_r <= next_vld;
    end else if (ctl.ins && lt) begin
      vld_r <= prev_lt ? prev_vld : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      addr_r <= next_addr;
      slot_r <= next_slot;
    end else if (ctl.ins && lt) begin
      addr_r <= prev_lt ? prev_addr : ins_addr;
      slot_r <= prev_lt ? prev_slot : ins_slot;
    end
  end

endmodule

@@ hdl/sors_chain.sv @@
// Row of sorting cells: ordered insertion and head extraction.
module sors_chain #(
  parameter int unsigned MAX_SLOTS = sors_pkg::DefMaxSlots,
  parameter int unsigned IDX_W     = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sors_pkg::chain_ctl_t       ctl,
  input  logic [sors_pkg::AddrW-1:0] ins_addr,
  input  logic [IDX_W-1:0]           ins_slot,
  output logic [sors_pkg::AddrW-1:0] head_addr,
  output logic [IDX_W-1:0]           head_slot,
  output logic                       head_vld
);
  import sors_pkg::*;

  logic [AddrW-1:0] addr  [MAX_SLOTS+1];
  logic [IDX_W-1:0] slot  [MAX_SLOTS+1];
  logic             vld   [MAX_SLOTS+1];
  logic             lt    [MAX_SLOTS+1];

  // Position MAX_SLOTS is a permanently empty tail feeding the last cell.
  assign addr[MAX_SLOTS] = '0;
  assign slot[MAX_SLOTS] = '0;
  assign vld[MAX_SLOTS]  = 1'b0;
  assign lt[MAX_SLOTS]   = 1'b1;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic             p_lt;
    logic [AddrW-1:0] p_addr;
    logic [IDX_W-1:0] p_slot;
    logic             p_vld;

    if (i == 0) begin : g_head
      assign p_lt   = 1'b0;
      assign p_addr = '0;
      assign p_slot = '0;
      assign p_vld  = 1'b0;
    end else begin : g_body
      assign p_lt   = lt[i-1];
      assign p_addr = addr[i-1];
      assign p_slot = slot[i-1];
      assign p_vld  = vld[i-1];
    end

    sors_cell #(.IDX_W(IDX_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ins_addr  (ins_addr),
      .ins_slot  (ins_slot),
      .prev_lt   (p_lt),
      .prev_addr (p_addr),
      .prev_slot (p_slot),
      .prev_vld  (p_vld),
      .next_addr (addr[i+1]),
      .next_slot (slot[i+1]),
      .next_vld  (vld[i+1]),
      .lt        (lt[i]),
      .addr_r    (addr[i]),
      .slot_r    (slot[i]),
      .vld_r     (vld[i])
    );
  end

  assign head_addr = addr[0];
  assign head_slot = slot[0];
  assign head_vld  = vld[0];

endmodule

@@ hdl/seek_order_record_scheduler.sv @@
// Top level of the seek-order record scheduler for one tape block.
//
// Requests arrive on in_if (req_type, disk_addr); results leave on out_if
// (kind, slot, read_addr, tape_full, last); cfg_if writes the four
// registers and is always ready. A data or disk record gives no result until
// the block is complete. On a flush, or when the last slot is taken, the
// free slots are padded with address 1 at one slot per cycle, then one read
// command leaves per cycle while the receiver is ready, in ascending
// address order (lower slot first on equal addresses), followed by one
// block-done result with last set. When the slot count was lowered under a
// partial block, each entry beyond the new count is dropped from the head
// without a result. The row of sorting cells takes one insertion or one
// extraction a cycle. Input is taken only while no block is being emptied.
// When the receiver stalls, the current result stays on out_if unchanged
// and the row holds still. Synchronous reset empties the row, clears the
// fill count and tape usage and restores the register defaults; no
// clearing pass is needed.
module seek_order_record_scheduler #(
  parameter int unsigned MAX_SLOTS = sors_pkg::DefMaxSlots
) (
  input  logic        clk,
  input  logic        rst_n,
  sors_chan_if.sink   in_if,
  sors_chan_if.source out_if,
  sors_chan_if.sink   cfg_if
);
  import sors_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] fill_count_r;
  logic [31:0]      tape_used_r;
  logic [5:0]       records_per_block_r;
  logic [15:0]      block_length_r;
  logic [7:0]       gap_length_r;
  logic [31:0]      tape_limit_r;

  in_item_t         in_item;
  cfg_item_t        cfg_item;
  logic             in_fire;
  logic             out_fire;
  logic             cfg_fire;
  logic [CNT_W-1:0] slots_n;
  logic             block_full;
  logic             record_ok;
  logic [CNT_W:0]   fill_inc;
  chain_ctl_t       ctl;
  logic [AddrW-1:0] ins_addr;
  logic [AddrW-1:0] head_addr;
  logic [IDX_W-1:0] head_slot;
  logic             head_vld;
  logic             head_live;
  logic [32:0]      usage_sum;
  logic             tape_full;
  out_item_t        out_item;

  assign in_item  = in_if.data;
  assign cfg_item = cfg_if.data;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;

  // Slot count in force: zero acts as one, anything beyond the row as the row.
  always_comb begin
    if (records_per_block_r == 6'd0) begin
      slots_n = CNT_W'(1);
    end else if (records_per_block_r > 6'(MAX_SLOTS)) begin
      slots_n = CNT_W'(MAX_SLOTS);
    end else begin
      slots_n = CNT_W'(records_per_block_r);
    end
  end

  assign block_full = (fill_count_r >= slots_n);
  assign fill_inc   = {1'b0, fill_count_r} + (CNT_W + 1)'(1);

  // A record that takes a slot: data records always, disk records with a
  // non-zero address. Unknown codes and skipped disk records fall out here.
  assign record_ok = (in_item.req_type == REQ_DATA) ||
                     ((in_item.req_type == REQ_DISK) && (in_item.disk_addr != '0));

  // Entries whose slot lies beyond a lowered slot count belong to no block
  // any more; they leave the head of the row without a result.
  assign head_live = head_vld && (CNT_W'(head_slot) < slots_n);

  // Only disk records and padding enter the row; data records need no read.
  always_comb begin
    ctl      = '0;
    ins_addr = in_item.disk_addr;
    if (state_r == ST_IDLE) begin
      ctl.ins = in_fire && (in_item.req_type == REQ_DISK) &&
                (in_item.disk_addr != '0) && !block_full;
    end else if (state_r == ST_PAD) begin
      ctl.ins  = !block_full;
      ins_addr = PAD_ADDR;
    end
    ctl.pop = (state_r == ST_DRAIN) && (out_fire || (head_vld && !head_live));
  end

  sors_chain #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .ins_addr  (ins_addr),
    .ins_slot  (fill_count_r[IDX_W-1:0]),
    .head_addr (head_addr),
    .head_slot (head_slot),
    .head_vld  (head_vld)
  );

  // Tape usage is summed without wrapping before the limit compare.
  assign usage_sum = {1'b0, tape_used_r} + 33'(block_length_r) + 33'(gap_length_r);
  assign tape_full = (usage_sum > {1'b0, tape_limit_r});

  always_comb begin
    out_item = '0;
    if (state_r == ST_DONE) begin
      out_item.kind      = KIND_DONE;
      out_item.tape_full = tape_full;
      out_item.last      = 1'b1;
    end else begin
      out_item.kind      = KIND_READ;
      out_item.slot      = 5'(head_slot);
      out_item.read_addr = head_addr;
    end
  end

  assign out_if.valid = ((state_r == ST_DRAIN) && head_live) || (state_r == ST_DONE);
  assign out_if.data  = out_item;

  // Sequencer: collect records, pad, drain the row, report block done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      tape_used_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_item.req_type == REQ_FLUSH) begin
              state_r <= ST_PAD;
            end else if (record_ok) begin
              if (block_full) begin
                // The block shrank under a partial block: drop and flush.
                state_r <= ST_PAD;
              end else begin
                fill_count_r <= fill_inc[CNT_W-1:0];
                if (fill_inc >= {1'b0, slots_n}) begin
                  state_r <= ST_PAD;
                end
              end
            end
          end
        end
        ST_PAD: begin
          if (block_full) begin
            state_r <= ST_DRAIN;
          end else begin
            fill_count_r <= fill_inc[CNT_W-1:0];
          end
        end
        ST_DRAIN: begin
          if (!head_vld) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_fire) begin
            state_r      <= ST_IDLE;
            fill_count_r <= '0;
            tape_used_r  <= tape_full ? 32'd0 : usage_sum[31:0];
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Config registers; user writes only while the block is idle, not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      records_per_block_r <= RST_RECORDS_PER_BLOCK;
      block_length_r      <= RST_BLOCK_LENGTH;
      gap_length_r        <= RST_GAP_LENGTH;
      tape_limit_r        <= RST_TAPE_LIMIT;
    end else if (cfg_fire) begin
      unique case (cfg_item.index)
        REG_RECORDS_PER_BLOCK: records_per_block_r <= cfg_item.value[5:0];
        REG_BLOCK_LENGTH:      block_length_r      <= cfg_item.value[15:0];
        REG_GAP_LENGTH:        gap_length_r        <= cfg_item.value[7:0];
        REG_TAPE_LIMIT:        tape_limit_r        <= cfg_item.value;
        default: begin
        end
      endcase
    end
  end

  // The block never takes input while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input accepted while a result is pending");

  // Completing a block always restarts slot filling from zero.
  a_fill_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_item.last) |=> (fill_count_r == '0))
    else $error("fill count not cleared after block done");

  // A reported tape change clears the usage counter.
  a_tape_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (out_item.kind == KIND_DONE) && out_item.tape_full)
      |=> (tape_used_r == 32'd0))
    else $error("tape usage not cleared on tape full");

  // The fill count never runs past the row.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(MAX_SLOTS))
    else $error("fill count beyond slot row");

endmodule

@@ dv/sors_tb_pkg.sv @@
`timescale 1ns / 1ps
// Read-order predictor and result checker for the seek-order record scheduler testbench.
package sors_tb_pkg;
  import sors_pkg::*;

  // Request code with no meaning; the block must ignore it.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Keeps its own copy of the registers, the slot store, the fill count and
  // the tape usage, and holds the results that are still due from the block.
  class seek_order_book;
    logic [5:0]       records_per_block;
    logic [15:0]      block_length;
    logic [7:0]       gap_length;
    logic [31:0]      tape_limit;
    logic [AddrW-1:0] slot_addr [DefMaxSlots];
    int unsigned      fill_count;
    logic [31:0]      tape_used;
    out_item_t        due_results [$];
    int unsigned      failures;

    function new();
      records_per_block = RST_RECORDS_PER_BLOCK;
      block_length      = RST_BLOCK_LENGTH;
      gap_length        = RST_GAP_LENGTH;
      tape_limit        = RST_TAPE_LIMIT;
      foreach (slot_addr[i]) slot_addr[i] = '0;
      fill_count = 0;
      tape_used  = '0;
      failures   = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_RECORDS_PER_BLOCK: records_per_block = value[5:0];
        REG_BLOCK_LENGTH:      block_length      = value[15:0];
        REG_GAP_LENGTH:        gap_length        = value[7:0];
        REG_TAPE_LIMIT:        tape_limit        = value;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // A slot count of zero behaves as one; anything above the store size is clipped.
    function int unsigned slots_in_block();
      if (records_per_block == 0) return 1;
      if (records_per_block > DefMaxSlots) return DefMaxSlots;
      return records_per_block;
    endfunction

    function void queue_result(logic kind, logic [4:0] slot, logic [AddrW-1:0] addr,
                               logic full, logic last);
      out_item_t r;
      r.kind      = kind;
      r.slot      = slot;
      r.read_addr = addr;
      r.tape_full = full;
      r.last      = last;
      due_results.push_back(r);
    endfunction

    // Pads the free slots, then issues the reads smallest address first and
    // lower slot first on a tie, and closes with the block-done result.
    function void close_block();
      int unsigned      n;
      int unsigned      best_slot;
      logic [AddrW-1:0] best;
      logic [32:0]      usage;
      bit               found;
      n = slots_in_block();
      for (int unsigned i = fill_count; i < n; i++) slot_addr[i] = PAD_ADDR;
      found = 1'b1;
      while (found) begin
        best      = '0;
        best_slot = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (slot_addr[i] != '0 && (best == '0 || slot_addr[i] < best)) begin
            best      = slot_addr[i];
            best_slot = i;
          end
        end
        found = (best != '0);
        if (found) begin
          queue_result(KIND_READ, 5'(best_slot), best, 1'b0, 1'b0);
          slot_addr[best_slot] = '0;
        end
      end
      fill_count = 0;
      usage = {1'b0, tape_used} + 33'(block_length) + 33'(gap_length);
      if (usage > {1'b0, tape_limit}) begin
        tape_used = '0;
        queue_result(KIND_DONE, '0, '0, 1'b1, 1'b1);
      end else begin
        tape_used = usage[31:0];
        queue_result(KIND_DONE, '0, '0, 1'b0, 1'b1);
      end
    endfunction

    function void note_request(in_item_t req);
      int unsigned n;
      n = slots_in_block();
      if (req.req_type == REQ_FLUSH) begin
        close_block();
        return;
      end
      if (req.req_type != REQ_DATA && req.req_type != REQ_DISK) return;
      if (req.req_type == REQ_DISK && req.disk_addr == '0) return;
      // A block that shrank below its fill drops the record and is flushed.
      if (fill_count >= n) begin
        close_block();
        return;
      end
      slot_addr[fill_count] = (req.req_type == REQ_DISK) ? req.disk_addr : '0;
      fill_count++;
      if (fill_count >= n) close_block();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d slot %0d read_addr %0h",
               got.kind, got.slot, got.read_addr);
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        failures++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
        failures++;
      end
      if (got.read_addr !== want.read_addr) begin
        $error("read_addr: expected %0h, actual %0h", want.read_addr, got.read_addr);
        failures++;
      end
      if (got.tape_full !== want.tape_full) begin
        $error("tape_full: expected %0d, actual %0d", want.tape_full, got.tape_full);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top-level testbench of the seek-order record scheduler with directed and random requests.
module testbench;
  import sors_pkg::*;
  import sors_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  // While this is set neither the sender nor the receiver idles, which gives
  // a long stretch of back-to-back transactions.
  bit   calm;
  seek_order_book book;

  sors_chan_if #(.payload_t(in_item_t))  in_if ();
  sors_chan_if #(.payload_t(out_item_t)) out_if ();
  sors_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  seek_order_record_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #6 clk = ~clk;

  // The receiver stalls with a probability of roughly eight percent. Ready only
  // changes on the falling edge, so it is stable around every rising edge.
  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= 8);
  end

  // Every result transaction is checked against the oldest result still due.
  // Values are read at the rising edge before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      book.check_result(out_if.data);
    end
  end

  // Ends the run if the block stops making progress; the slowest correct run
  // is a small fraction of this.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Offers one request, idling first now and then, and records it in the
  // predictor once the transaction has taken place. Entered and left on a
  // falling edge; valid is left high so that the next request follows at once.
  task automatic send_request(logic [1:0] req_type, logic [AddrW-1:0] disk_addr);
    in_item_t req;
    req.req_type  = req_type;
    req.disk_addr = disk_addr;
    while (!calm && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    do @(posedge clk); while (!in_if.ready);
    book.note_request(req);
    @(negedge clk);
  endtask

  // One register write. The callers lower valid once their writes are done.
  task automatic write_register(logic [1:0] index, logic [31:0] value);
    cfg_item_t w;
    w.index = index;
    w.value = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk); while (!cfg_if.ready);
    book.write_register(index, value);
    @(negedge clk);
  endtask

  // Writes all four registers. The bits above each register's width carry
  // noise, which the block has to drop.
  task automatic apply_settings(logic [5:0] slots, logic [15:0] blen, logic [7:0] gap,
                                logic [31:0] limit);
    write_register(REG_RECORDS_PER_BLOCK, ($urandom() & ~32'h3F) | 32'(slots));
    write_register(REG_BLOCK_LENGTH, ($urandom() & ~32'hFFFF) | 32'(blen));
    write_register(REG_GAP_LENGTH, ($urandom() & ~32'hFF) | 32'(gap));
    write_register(REG_TAPE_LIMIT, limit);
    cfg_if.valid <= 1'b0;
  endtask

  // Holds the sender back until every due result has arrived and a record
  // still being stored has settled.
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (book.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Mostly well-formed records with random content; a few flushes, skipped
  // disk records and unknown codes as noise. Ignored requests are not counted.
  task automatic send_random(output bit counted);
    int unsigned      pick;
    logic [AddrW-1:0] addr;
    pick    = $urandom_range(99);
    addr    = AddrW'($urandom());
    counted = 1'b1;
    if (pick < 3) begin
      send_request(REQ_UNKNOWN, addr);
      counted = 1'b0;
    end else if (pick < 6) begin
      send_request(REQ_DISK, '0);
      counted = 1'b0;
    end else if (pick < 12) begin
      send_request(REQ_FLUSH, addr);
    end else if (pick < 35) begin
      send_request(REQ_DATA, addr);
    end else begin
      // Small and near-top addresses give plenty of ties, the small ones also with padding.
      case ($urandom_range(2))
        0: ;
        1: addr = AddrW'($urandom_range(8, 1));
        default: addr = ~AddrW'($urandom_range(7));
      endcase
      if (addr == '0) addr = PAD_ADDR;
      send_request(REQ_DISK, addr);
    end
  endtask

  initial begin
    int unsigned sent;
    bit          counted;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    calm         = 1'b0;
    rst_n        = 1'b0;
    book         = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset register values (ten slots a block).
    // A flush of an empty block pads and reads every slot.
    send_request(REQ_FLUSH, '0);
    // An unknown code and a disk record with address zero are both ignored.
    send_request(REQ_UNKNOWN, '1);
    send_request(REQ_DISK, '0);
    // A partial block with the extreme addresses, ties among the records and
    // ties with the padding, closed by a flush.
    send_request(REQ_DISK, '1);
    send_request(REQ_DISK, PAD_ADDR);
    send_request(REQ_DATA, '1);
    send_request(REQ_DISK, AddrW'(5));
    send_request(REQ_DISK, AddrW'(5));
    send_request(REQ_DISK, PAD_ADDR);
    send_request(REQ_FLUSH, '1);
    // A full block, which empties itself on the tenth record.
    send_request(REQ_DISK, AddrW'(31'h4000_0000));
    send_request(REQ_DATA, '0);
    send_request(REQ_DISK, AddrW'(3));
    send_request(REQ_DISK, '1);
    send_request(REQ_DISK, AddrW'(3));
    send_request(REQ_DISK, AddrW'(2));
    send_request(REQ_DATA, AddrW'(31'h5555_5555));
    send_request(REQ_DATA, '0);
    send_request(REQ_DISK, PAD_ADDR);
    send_request(REQ_DISK, AddrW'(31'h2AAA_AAAA));
    // The block shrinks under a partial block: the next record is dropped and
    // only the slots of the new size are read.
    send_request(REQ_DISK, AddrW'(9));
    send_request(REQ_DISK, AddrW'(8));
    send_request(REQ_DISK, AddrW'(7));
    wait_quiet();
    write_register(REG_RECORDS_PER_BLOCK, 32'd2);
    cfg_if.valid <= 1'b0;
    send_request(REQ_DATA, '0);

    // Random part: every phase starts from an idle block with new settings,
    // so the sender waits for all due results before each of them.
    for (int phase = 0; phase < 10; phase++) begin
      wait_quiet();
      case (phase)
        0: apply_settings(6'd1, 16'd0, 8'd0, 32'd0);
        1: apply_settings(6'd0, 16'hFFFF, 8'hFF, 32'd200_000);
        2: apply_settings(6'd63, 16'd1, 8'd1, 32'hFFFF_FFFF);
        3: apply_settings(6'd32, 16'hFFFF, 8'hFF, 32'd0);
        4: apply_settings(6'd2, 16'($urandom()), 8'($urandom()),
                          $urandom_range(300_000));
        default: apply_settings(6'($urandom_range(12, 1)), 16'($urandom()),
                                8'($urandom()),
                                $urandom_range(1) ? $urandom() : $urandom_range(300_000));
      endcase
      calm <= (phase == 4 || phase == 5);
      sent = 0;
      while (sent < 22) begin
        send_random(counted);
        sent += counted;
      end
    end

    wait_quiet();
    if (book.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ seek_order_record_scheduler.f @@
hdl/sors_pkg.sv
hdl/sors_chan_if.sv
hdl/sors_cell.sv
hdl/sors_chain.sv
hdl/seek_order_record_scheduler.sv
dv/sors_tb_pkg.sv
dv/testbench.sv
